@@ design/lgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the Lab neighbor gradient stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Configuration port.
    localparam int          CFG_WIDTH      = 13;
    localparam int          CFG_ADDR_WIDTH = 1;
    localparam logic [0:0]  REG_FRAME_COLS = 1'b0;
    localparam logic [0:0]  REG_FRAME_ROWS = 1'b1;
    localparam logic [12:0] COLS_RESET     = 13'd640;
    localparam logic [12:0] ROWS_RESET     = 13'd480;

    // Frame geometry limits.
    localparam int ROW_WIDTH = 13;
    localparam int ROW_LIMIT = 4096;

    // Neighbor weights in Q0.16: orthogonal (2-sqrt2)/4, diagonal (sqrt2-1)/4.
    localparam int          WEIGHT_WIDTH = 14;
    localparam logic [13:0] W_ORTHO      = 14'd9598;
    localparam logic [13:0] W_DIAG       = 14'd6786;

    // Rounding from Q8.24 to Q8.8.
    localparam int RND_SHIFT = 16;
    localparam int RND_HALF  = 32768;

    // Result word.
    localparam int GRAD_WIDTH     = 18;
    localparam int OUT_DATA_WIDTH = 24;

    // Output queue and credit counter.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CREDIT_W   = 4;

    // Per-item control that travels down the pipeline.
    typedef struct packed {
        logic       have;
        logic       last;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } t_ctrl;

endpackage

@@ design/lab_gradient_8neighbor_stencil.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_gradient_8neighbor_stencil
// Weighted 8-neighbor L1 gradient over a raster stream of Lab feature pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one word per pixel, with
// s_axis_tuser marking flush words. Each result leaves on the m_axis channel
// with the gradient in Q8.8 and m_axis_tlast on the final pixel of the frame.
// A pixel's result needs its whole 3x3 window, so it is produced by the input
// word one row plus one pixel later; after the last pixel the source sends
// frame_cols+1 flush words. Frame size is set on the plain write port while
// the block is idle; a write restarts the frame position.
// Throughput is one word per cycle on both sides while the receiver keeps up.
// The single line RAM is read at the column of the incoming word and written
// back in the next cycle, with a forwarding register when the next word hits
// the same column. Results pass registers s1 to s6 and the output queue.
// Reset clears the frame position, the pipeline and the output queue; the
// line RAM needs no clearing pass. When the receiver stalls, results collect
// in an 8-entry queue and s_axis_tready drops once results already accepted
// or in flight would fill it.
// ----------------------------------------------------------------------------
module lab_gradient_8neighbor_stencil #(
    parameter int MAX_COLS      = 4096,
    parameter int NUM_FEATURES  = 3,
    parameter int FEATURE_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [lgs_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [lgs_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,

    // Pixel input.
    input  logic                                                   s_axis_tvalid,
    output logic                                                   s_axis_tready,
    // Fields from bit 0: feat_l, feat_a, feat_b, zero fill.
    input  logic [((NUM_FEATURES*FEATURE_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    // Fields from bit 0: is_padding.
    input  logic                                                   s_axis_tuser,

    // Gradient output.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: gradient, zero fill.
    output logic [lgs_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,
    // Fields: last_of_frame.
    output logic                                  m_axis_tlast
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int CCW  = CW + 1;
    localparam int RW   = lgs_pkg::ROW_WIDTH;
    localparam int FW   = FEATURE_WIDTH;
    localparam int NF   = NUM_FEATURES;
    localparam int PXW  = NF * FW;
    localparam int DW   = FW + $clog2(NF);
    localparam int GW   = DW + 2;
    localparam int PRW  = GW + lgs_pkg::WEIGHT_WIDTH;
    localparam int AW   = PRW + 2;
    localparam int GOW  = AW - lgs_pkg::RND_SHIFT;
    localparam int QW   = lgs_pkg::GRAD_WIDTH + 1;
    localparam longint unsigned GRAD_MAX = longint'(NF) * ((64'd1 << FW) - 64'd1);
    localparam longint unsigned OUT_MAX  = (64'd1 << lgs_pkg::GRAD_WIDTH) - 64'd1;
    localparam longint unsigned SAT      = (GRAD_MAX < OUT_MAX) ? GRAD_MAX : OUT_MAX;

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    logic [lgs_pkg::CFG_WIDTH-1:0] r_frame_cols;
    logic [lgs_pkg::CFG_WIDTH-1:0] r_frame_rows;
    logic [CCW-1:0]                cols_eff;
    logic [RW-1:0]                 rows_eff;

    logic [CW-1:0]  r_in_col;
    logic [RW-1:0]  r_in_row;
    logic [CW-1:0]  n_in_col;
    logic [RW-1:0]  n_in_row;

    logic           in_acc;
    logic [CW-1:0]  col_cur;
    logic [CCW-1:0] col_inc;
    logic [RW:0]    row_inc;
    logic           have_pos;
    logic           have;
    logic           last;
    logic [CW-1:0]  cc;
    logic [RW-1:0]  cr;
    lgs_pkg::t_ctrl ctrl_in;
    logic [PXW-1:0] pix_in;
    logic           fwd;

    logic                r_s1_valid;
    logic [CW-1:0]       r_s1_col;
    logic [PXW-1:0]      r_s1_pix;
    logic                r_s1_fwd;
    lgs_pkg::t_ctrl      r_s1_ctrl;
    logic [2*PXW-1:0]    ram_rdata;
    logic [2*PXW-1:0]    s1_word;
    logic [2*PXW-1:0]    wr_word;
    logic [2*PXW-1:0]    r_last_wr;

    logic [PXW-1:0]      r_win [3][3];
    logic                r_s2_valid;
    lgs_pkg::t_ctrl      r_s2_ctrl;

    logic signed [FW:0]  diff [3][3][NF];
    logic [FW-1:0]       mag  [3][3][NF];
    logic [FW-1:0]       r_s3_mag [3][3][NF];
    logic                r_s3_valid;
    lgs_pkg::t_ctrl      r_s3_ctrl;

    logic [DW-1:0]       dist_sum [3][3];
    logic [DW-1:0]       r_s4_dist [3][3];
    logic                r_s4_valid;
    logic                r_s4_last;

    logic [GW-1:0]       r_s5_ortho;
    logic [GW-1:0]       r_s5_diag;
    logic                r_s5_valid;
    logic                r_s5_last;

    logic [PRW-1:0]      r_s6_po;
    logic [PRW-1:0]      r_s6_pd;
    logic                r_s6_valid;
    logic                r_s6_last;

    logic [AW-1:0]                     acc_sum;
    logic [GOW-1:0]                    grad_raw;
    logic [lgs_pkg::GRAD_WIDTH-1:0]    grad_sat;

    logic [QW-1:0]                     r_fifo_mem [lgs_pkg::FIFO_DEPTH];
    logic [lgs_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [lgs_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [lgs_pkg::CREDIT_W-1:0]      r_fifo_count;
    logic [lgs_pkg::CREDIT_W-1:0]      r_credit;
    logic                              push;
    logic                              pop;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols <= lgs_pkg::COLS_RESET;
            r_frame_rows <= lgs_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lgs_pkg::REG_FRAME_COLS: r_frame_cols <= i_cfg_wdata;
                lgs_pkg::REG_FRAME_ROWS: r_frame_rows <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the frame size into the supported range.
    always_comb begin
        if (r_frame_cols == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_frame_cols) > MAX_COLS) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(r_frame_cols);
        end
        if (r_frame_rows == '0) begin
            rows_eff = RW'(1);
        end else if (32'(r_frame_rows) > lgs_pkg::ROW_LIMIT) begin
            rows_eff = RW'(lgs_pkg::ROW_LIMIT);
        end else begin
            rows_eff = RW'(r_frame_rows);
        end
    end

    // ------------------------------------------------------------------------
    // Input stage: frame position, window center and border flags
    // ------------------------------------------------------------------------
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign pix_in = s_axis_tuser ? '0 : s_axis_tdata[PXW-1:0];

    always_comb begin
        col_cur  = ({1'b0, r_in_col} >= cols_eff) ? '0 : r_in_col;
        have_pos = 1'b0;
        cc       = '0;
        cr       = '0;
        // The new word completes the window of the pixel up one row and left
        // one column; on column zero that pixel ends the row two rows up.
        if (col_cur != '0 && r_in_row != '0) begin
            have_pos = 1'b1;
            cc       = col_cur - CW'(1);
            cr       = r_in_row - RW'(1);
        end else if (col_cur == '0 && r_in_row >= RW'(2)) begin
            have_pos = 1'b1;
            cc       = CW'(cols_eff - CCW'(1));
            cr       = r_in_row - RW'(2);
        end
        have = have_pos && (cr < rows_eff);
        last = have && (cr == rows_eff - RW'(1)) && ({1'b0, cc} == cols_eff - CCW'(1));

        ctrl_in.have      = have;
        ctrl_in.last      = last;
        ctrl_in.row_ok[0] = (cr != '0);
        ctrl_in.row_ok[1] = 1'b1;
        ctrl_in.row_ok[2] = (({1'b0, cr} + (RW+1)'(1)) < {1'b0, rows_eff});
        ctrl_in.col_ok[0] = (cc != '0);
        ctrl_in.col_ok[1] = 1'b1;
        ctrl_in.col_ok[2] = (({1'b0, cc} + CCW'(1)) < cols_eff);

        // Next position, restarting after the final pixel of the frame.
        col_inc = {1'b0, col_cur} + CCW'(1);
        row_inc = {1'b0, r_in_row} + (RW+1)'(1);
        if (last) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (col_inc >= cols_eff) begin
            n_in_col = '0;
            if (row_inc > (RW+1)'(lgs_pkg::ROW_LIMIT + 1)) begin
                n_in_row = RW'(lgs_pkg::ROW_LIMIT + 1);
            end else begin
                n_in_row = row_inc[RW-1:0];
            end
        end else begin
            n_in_col = col_inc[CW-1:0];
            n_in_row = r_in_row;
        end
    end

    // The previous word writes this column back in the same cycle.
    assign fwd = r_s1_valid && (r_s1_col == col_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (i_cfg_we) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (in_acc) begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col  <= col_cur;
        r_s1_pix  <= pix_in;
        r_s1_fwd  <= fwd;
        r_s1_ctrl <= ctrl_in;
    end

    // ------------------------------------------------------------------------
    // Line RAM: upper row in the high half, middle row in the low half
    // ------------------------------------------------------------------------
    lgs_ram #(
        .WIDTH (2 * PXW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (wr_word),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    // Read-modify-write: the middle row moves up and the new pixel goes in.
    assign s1_word = r_s1_fwd ? r_last_wr : ram_rdata;
    assign wr_word = {s1_word[PXW-1:0], r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_last_wr <= wr_word;
        end
    end

    // ------------------------------------------------------------------------
    // 3x3 window shift
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= s1_word[2*PXW-1:PXW];
            r_win[1][2] <= s1_word[PXW-1:0];
            r_win[2][2] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctrl <= r_s1_ctrl;
    end

    // ------------------------------------------------------------------------
    // Absolute component differences against the center pixel
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int f = 0; f < NF; f++) begin
                    diff[i][j][f] = $signed({r_win[i][j][f*FW+FW-1], r_win[i][j][f*FW +: FW]})
                                  - $signed({r_win[1][1][f*FW+FW-1], r_win[1][1][f*FW +: FW]});
                    mag[i][j][f]  = diff[i][j][f][FW] ? FW'(-diff[i][j][f])
                                                      : FW'(diff[i][j][f]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid && r_s2_ctrl.have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_mag  <= mag;
        r_s3_ctrl <= r_s2_ctrl;
    end

    // ------------------------------------------------------------------------
    // Per-neighbor L1 distance, zero for the center and outside the frame
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                dist_sum[i][j] = '0;
                for (int f = 0; f < NF; f++) begin
                    dist_sum[i][j] = dist_sum[i][j] + DW'(r_s3_mag[i][j][f]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_s3_ctrl.row_ok[i] && r_s3_ctrl.col_ok[j] && !(i == 1 && j == 1)) begin
                    r_s4_dist[i][j] <= dist_sum[i][j];
                end else begin
                    r_s4_dist[i][j] <= '0;
                end
            end
        end
        r_s4_last <= r_s3_ctrl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Orthogonal and diagonal group sums
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s5_ortho <= GW'(r_s4_dist[0][1]) + GW'(r_s4_dist[1][0])
                    + GW'(r_s4_dist[1][2]) + GW'(r_s4_dist[2][1]);
        r_s5_diag  <= GW'(r_s4_dist[0][0]) + GW'(r_s4_dist[0][2])
                    + GW'(r_s4_dist[2][0]) + GW'(r_s4_dist[2][2]);
        r_s5_last  <= r_s4_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else begin
            r_s5_valid <= r_s4_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Weighting
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s6_po   <= PRW'(r_s5_ortho) * PRW'(lgs_pkg::W_ORTHO);
        r_s6_pd   <= PRW'(r_s5_diag) * PRW'(lgs_pkg::W_DIAG);
        r_s6_last <= r_s5_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else begin
            r_s6_valid <= r_s5_valid;
        end
    end

    // Round half up to Q8.8 and saturate.
    always_comb begin
        acc_sum  = AW'(r_s6_po) + AW'(r_s6_pd) + AW'(lgs_pkg::RND_HALF);
        grad_raw = acc_sum[AW-1:lgs_pkg::RND_SHIFT];
        if (64'(grad_raw) > SAT) begin
            grad_sat = lgs_pkg::GRAD_WIDTH'(SAT);
        end else begin
            grad_sat = lgs_pkg::GRAD_WIDTH'(grad_raw);
        end
    end

    // ------------------------------------------------------------------------
    // Output queue with credit-based input flow control
    // ------------------------------------------------------------------------
    assign push = r_s6_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_mem[r_wr_ptr] <= {r_s6_last, grad_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
            r_credit     <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + lgs_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + lgs_pkg::FIFO_AW'(1);
            end
            r_fifo_count <= r_fifo_count + lgs_pkg::CREDIT_W'(push)
                          - lgs_pkg::CREDIT_W'(pop);
            // Credits cover results in flight plus results queued.
            r_credit     <= r_credit + lgs_pkg::CREDIT_W'(in_acc && have)
                          - lgs_pkg::CREDIT_W'(pop);
        end
    end

    assign s_axis_tready = (r_credit < lgs_pkg::CREDIT_W'(lgs_pkg::FIFO_DEPTH));
    assign m_axis_tvalid = (r_fifo_count != '0);
    assign m_axis_tdata  = lgs_pkg::OUT_DATA_WIDTH'(r_fifo_mem[r_rd_ptr][lgs_pkg::GRAD_WIDTH-1:0]);
    assign m_axis_tlast  = r_fifo_mem[r_rd_ptr][lgs_pkg::GRAD_WIDTH];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Every queued result was paid for by a credit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_count <= r_credit)
        else $error("output queue holds more words than credits taken");

    // The column position always stays inside the frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_in_col} < cols_eff)
        else $error("input column outside the frame");

    // The final pixel of a frame restarts the position.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last && !i_cfg_we) |=> (r_in_col == '0 && r_in_row == '0))
        else $error("frame position not restarted after the last pixel");

endmodule

@@ design/lgs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
